>>> design/fmhp_pkg.sv
package fmhp_pkg;

  localparam int unsigned HdrBytes = 28;
  localparam int unsigned FillW = 5;

  localparam int unsigned FlEth  = 0;
  localparam int unsigned FlSnap = 1;
  localparam int unsigned FlVlan = 2;
  localparam int unsigned FlMpls = 3;
  localparam int unsigned FlIpv4 = 4;
  localparam int unsigned FlArp  = 5;
  localparam int unsigned FlTcp  = 6;
  localparam int unsigned FlUdp  = 7;
  localparam int unsigned FlSctp = 8;
  localparam int unsigned FlIcmp = 9;
  localparam int unsigned FlTtl  = 10;
  localparam int unsigned FlFrag = 11;

  localparam logic [15:0] EtVlan  = 16'h8100;
  localparam logic [15:0] EtQinq  = 16'h88a8;
  localparam logic [15:0] EtMplsU = 16'h8847;
  localparam logic [15:0] EtMplsM = 16'h8848;
  localparam logic [15:0] EtArp   = 16'h0806;
  localparam logic [15:0] EtIpv4  = 16'h0800;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoSctp = 8'd132;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] port;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] port_out;
    logic [47:0] mac_source;
    logic [47:0] mac_dest;
    logic [15:0] ether_kind;
    logic [18:0] vlan_info;
    logic [22:0] mpls_info;
    logic [5:0]  dscp;
    logic [7:0]  net_proto;
    logic [63:0] net_addrs;
    logic [31:0] port_pair;
    logic [11:0] layer_flags;
  } match_rec_t;

endpackage

>>> design/flow_match_header_parser_core.sv
// Channel | Handshake              | Payload
// in      | in_valid_i/in_ready_o  | data_byte_i, last_byte_i, in_port_i
// out     | out_valid_o/out_ready_i| port_out_o .. layer_flags_o
//
// One byte per cycle sustained unless the output stalls; the parser consumes
// one queued byte per cycle. A record becomes valid once its last byte has
// passed the byte queue and the parser has registered it on taking that byte.
// Reset empties the queue and clears the parse state and the output valid flag.
// A stalled output register holds the parser; the byte queue absorbs
// up to QueueDepth bytes before in_ready_o drops.
module flow_match_header_parser_core #(
  parameter int unsigned MaxFrameBytes = 16384,
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] in_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] port_out_o,
  output logic [47:0] mac_source_o,
  output logic [47:0] mac_dest_o,
  output logic [15:0] ether_kind_o,
  output logic [18:0] vlan_info_o,
  output logic [22:0] mpls_info_o,
  output logic [5:0]  dscp_o,
  output logic [7:0]  net_proto_o,
  output logic [63:0] net_addrs_o,
  output logic [31:0] port_pair_o,
  output logic [11:0] layer_flags_o
);

  fmhp_pkg::byte_item_t push_item, head;
  fmhp_pkg::match_rec_t rec;
  logic full, nonempty, pop;

  assign push_item = '{data: data_byte_i, last: last_byte_i, port: in_port_i};
  assign in_ready_o = !full;

  fmhp_byte_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(in_valid_i), .push_item_i(push_item), .full_o(full),
    .pop_i(pop), .nonempty_o(nonempty), .head_o(head)
  );

  fmhp_parser #(.MaxFrameBytes(MaxFrameBytes)) u_parser (
    .clk_i, .rst_ni,
    .item_valid_i(nonempty), .item_i(head), .item_ready_o(pop),
    .rec_valid_o(out_valid_o), .rec_o(rec), .rec_ready_i(out_ready_i)
  );

  assign port_out_o    = rec.port_out;
  assign mac_source_o  = rec.mac_source;
  assign mac_dest_o    = rec.mac_dest;
  assign ether_kind_o  = rec.ether_kind;
  assign vlan_info_o   = rec.vlan_info;
  assign mpls_info_o   = rec.mpls_info;
  assign dscp_o        = rec.dscp;
  assign net_proto_o   = rec.net_proto;
  assign net_addrs_o   = rec.net_addrs;
  assign port_pair_o   = rec.port_pair;
  assign layer_flags_o = rec.layer_flags;

endmodule

>>> design/fmhp_byte_queue.sv
module fmhp_byte_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fmhp_pkg::byte_item_t push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                nonempty_o,
  output fmhp_pkg::byte_item_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fmhp_pkg::byte_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

>>> design/fmhp_parser.sv
module fmhp_parser #(
  parameter int unsigned MaxFrameBytes = 16384
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  fmhp_pkg::byte_item_t item_i,
  output logic                 item_ready_o,
  output logic                 rec_valid_o,
  output fmhp_pkg::match_rec_t rec_o,
  input  logic                 rec_ready_i
);

  localparam int unsigned OffW = $clog2(MaxFrameBytes + 1);
  localparam int unsigned FW = fmhp_pkg::FillW;

  typedef enum logic [2:0] {
    PhEth, PhVlan, PhMpls, PhArp, PhIpv4, PhL4, PhDone
  } phase_e;

  phase_e phase_q, phase_d;
  logic [OffW-1:0] off_q, off_d;
  logic [FW-1:0] fill_q, fill_d, need_q, need_d, n;
  logic [3:0] l4bit_q, l4bit_d;
  logic [7:0] store_q [fmhp_pkg::HdrBytes];
  logic [7:0] v [fmhp_pkg::HdrBytes];
  logic [31:0] port_q, port_d;
  logic [47:0] msrc_q, msrc_d, mdst_q, mdst_d;
  logic [15:0] et_q, et_d;
  logic [18:0] vlan_q, vlan_d;
  logic [22:0] mpls_q, mpls_d;
  logic [5:0] dscp_q, dscp_d;
  logic [7:0] proto_q, proto_d, mttl_q, mttl_d, ittl_q, ittl_d;
  logic [63:0] addrs_q, addrs_d;
  logic [31:0] ports_q, ports_d;
  logic [11:0] fl_q, fl_d;
  logic disp, disp_eth, step, ttl_ok;
  logic [15:0] disp_et;
  logic [31:0] w;
  fmhp_pkg::match_rec_t rec_q, rec_d;
  logic rec_valid_q, rec_valid_d;

  assign item_ready_o = !rec_valid_q || rec_ready_i;
  assign step = item_valid_i && item_ready_o;
  assign rec_valid_o = rec_valid_q;
  assign rec_o = rec_q;
  assign n = fill_q + 1'b1;

  always_comb begin
    for (int k = 0; k < fmhp_pkg::HdrBytes; k++) begin
      v[k] = (fill_q == FW'(k)) ? item_i.data : store_q[k];
    end
  end

  always_comb begin
    phase_d = phase_q; off_d = off_q; fill_d = fill_q; need_d = need_q;
    l4bit_d = l4bit_q; port_d = port_q; msrc_d = msrc_q; mdst_d = mdst_q;
    et_d = et_q; vlan_d = vlan_q; mpls_d = mpls_q; dscp_d = dscp_q;
    proto_d = proto_q; mttl_d = mttl_q; ittl_d = ittl_q; addrs_d = addrs_q;
    ports_d = ports_q; fl_d = fl_q;
    disp = 1'b0; disp_eth = 1'b0; disp_et = '0;
    w = {v[0], v[1], v[2], v[3]};
    rec_valid_d = rec_valid_q && !rec_ready_i;
    rec_d = rec_q;
    ttl_ok = 1'b1;
    if (step) begin
      if (off_q == '0) port_d = item_i.port;
      if (off_q < OffW'(MaxFrameBytes)) begin
        off_d = off_q + 1'b1;
        if (phase_q != PhDone) begin
          fill_d = n;
          case (phase_q)
            PhEth: begin
              if (n == FW'(14)) begin
                fl_d[fmhp_pkg::FlEth] = 1'b1;
                if ({v[12], v[13]} >= 16'h0600) begin
                  mdst_d = {v[0], v[1], v[2], v[3], v[4], v[5]};
                  msrc_d = {v[6], v[7], v[8], v[9], v[10], v[11]};
                  disp = 1'b1; disp_eth = 1'b1; disp_et = {v[12], v[13]};
                end
              end else if (n == FW'(17)) begin
                if ({v[14], v[15], v[16]} != 24'haaaa03) phase_d = PhDone;
              end else if (n == FW'(22)) begin
                fl_d[fmhp_pkg::FlSnap] = 1'b1;
                if ({v[17], v[18], v[19]} != 24'h0) begin
                  phase_d = PhDone;
                end else begin
                  mdst_d = {v[0], v[1], v[2], v[3], v[4], v[5]};
                  msrc_d = {v[6], v[7], v[8], v[9], v[10], v[11]};
                  disp = 1'b1; disp_eth = 1'b1; disp_et = {v[20], v[21]};
                end
              end
            end
            PhVlan: begin
              if (n == FW'(4)) begin
                if (!fl_q[fmhp_pkg::FlVlan]) begin
                  fl_d[fmhp_pkg::FlVlan] = 1'b1;
                  vlan_d = {4'h0, v[0][3:0], v[1], v[0][7:5]};
                end
                disp = 1'b1; disp_et = {v[2], v[3]};
              end
            end
            PhMpls: begin
              if (n == FW'(4)) begin
                fl_d[fmhp_pkg::FlMpls] = 1'b1;
                mpls_d = {w[31:12], w[11:9]};
                mttl_d = v[3];
                phase_d = PhDone;
              end
            end
            PhArp: begin
              if (n == FW'(28)) begin
                fl_d[fmhp_pkg::FlArp] = 1'b1;
                if ({v[0], v[1]} == 16'd1 && {v[2], v[3]} == fmhp_pkg::EtIpv4 &&
                    v[4] == 8'd6 && v[5] == 8'd4 && v[6] == 8'd0) begin
                  proto_d = v[7];
                  if (v[7] == 8'd1 || v[7] == 8'd2) begin
                    addrs_d = {v[14], v[15], v[16], v[17], v[24], v[25], v[26], v[27]};
                  end
                end
                phase_d = PhDone;
              end
            end
            PhIpv4: begin
              if (n == FW'(20)) begin
                fl_d[fmhp_pkg::FlIpv4] = 1'b1;
                addrs_d = {v[12], v[13], v[14], v[15], v[16], v[17], v[18], v[19]};
                dscp_d = v[1][7:2];
                proto_d = v[9];
                ittl_d = v[8];
                phase_d = PhDone;
                fill_d = '0;
                if ({v[6][5:0], v[7]} != 14'h0) begin
                  fl_d[fmhp_pkg::FlFrag] = 1'b1;
                end else if (v[9] == fmhp_pkg::ProtoTcp) begin
                  need_d = FW'(20); l4bit_d = 4'(fmhp_pkg::FlTcp); phase_d = PhL4;
                end else if (v[9] == fmhp_pkg::ProtoUdp) begin
                  need_d = FW'(8); l4bit_d = 4'(fmhp_pkg::FlUdp); phase_d = PhL4;
                end else if (v[9] == fmhp_pkg::ProtoIcmp) begin
                  need_d = FW'(4); l4bit_d = 4'(fmhp_pkg::FlIcmp); phase_d = PhL4;
                end else if (v[9] == fmhp_pkg::ProtoSctp) begin
                  need_d = FW'(12); l4bit_d = 4'(fmhp_pkg::FlSctp); phase_d = PhL4;
                end
              end
            end
            PhL4: begin
              if (n == need_q) begin
                fl_d[l4bit_q] = 1'b1;
                if (l4bit_q == 4'(fmhp_pkg::FlIcmp)) ports_d = {8'h0, v[0], 8'h0, v[1]};
                else ports_d = w;
                phase_d = PhDone;
              end
            end
            default: ;
          endcase
          if (disp) begin
            et_d = disp_et;
            fill_d = '0;
            if (disp_et == fmhp_pkg::EtVlan || disp_et == fmhp_pkg::EtQinq) begin
              phase_d = PhVlan;
            end else begin
              if (disp_eth) vlan_d = 19'h7fff8;
              if (disp_et == fmhp_pkg::EtMplsU || disp_et == fmhp_pkg::EtMplsM) begin
                phase_d = PhMpls;
              end else if (disp_et == fmhp_pkg::EtArp) begin
                phase_d = PhArp;
              end else if (disp_et == fmhp_pkg::EtIpv4) begin
                phase_d = PhIpv4;
              end else begin
                phase_d = PhDone;
              end
            end
          end
        end
      end
      if (item_i.last) begin
        ttl_ok = !(fl_d[fmhp_pkg::FlMpls] && mttl_d <= 8'd1) &&
                 !(fl_d[fmhp_pkg::FlIpv4] && ittl_d <= 8'd1);
        rec_valid_d = 1'b1;
        rec_d.port_out = port_d;
        rec_d.mac_source = msrc_d;
        rec_d.mac_dest = mdst_d;
        rec_d.ether_kind = et_d;
        rec_d.vlan_info = vlan_d;
        rec_d.mpls_info = mpls_d;
        rec_d.dscp = dscp_d;
        rec_d.net_proto = proto_d;
        rec_d.net_addrs = addrs_d;
        rec_d.port_pair = ports_d;
        rec_d.layer_flags = {fl_d[fmhp_pkg::FlFrag], ttl_ok, fl_d[9:0]};
        phase_d = PhEth; off_d = '0; fill_d = '0; need_d = '0; l4bit_d = '0;
        msrc_d = '0; mdst_d = '0; et_d = '0; vlan_d = '0; mpls_d = '0;
        dscp_d = '0; proto_d = '0; mttl_d = '0; ittl_d = '0; addrs_d = '0;
        ports_d = '0; fl_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhEth; off_q <= '0; fill_q <= '0; need_q <= '0; l4bit_q <= '0;
      port_q <= '0; msrc_q <= '0; mdst_q <= '0; et_q <= '0; vlan_q <= '0;
      mpls_q <= '0; dscp_q <= '0; proto_q <= '0; mttl_q <= '0; ittl_q <= '0;
      addrs_q <= '0; ports_q <= '0; fl_q <= '0; rec_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; off_q <= off_d; fill_q <= fill_d; need_q <= need_d;
      l4bit_q <= l4bit_d; port_q <= port_d; msrc_q <= msrc_d; mdst_q <= mdst_d;
      et_q <= et_d; vlan_q <= vlan_d; mpls_q <= mpls_d; dscp_q <= dscp_d;
      proto_q <= proto_d; mttl_q <= mttl_d; ittl_q <= ittl_d; addrs_q <= addrs_d;
      ports_q <= ports_d; fl_q <= fl_d; rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (step && off_q < OffW'(MaxFrameBytes) && phase_q != PhDone &&
        fill_q < FW'(fmhp_pkg::HdrBytes)) begin
      store_q[fill_q] <= item_i.data;
    end
  end

endmodule

>>> design/fmhp_checker.sv
module fmhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] net_addrs_o,
  input logic [11:0] layer_flags_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(net_addrs_o)
      && $stable(layer_flags_o))
    else $error("held record changed");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("record valid in reset");

  a_l4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (layer_flags_o[fmhp_pkg::FlTcp] || layer_flags_o[fmhp_pkg::FlUdp] ||
      layer_flags_o[fmhp_pkg::FlSctp] || layer_flags_o[fmhp_pkg::FlIcmp])
    |-> layer_flags_o[fmhp_pkg::FlIpv4] && !layer_flags_o[fmhp_pkg::FlFrag])
    else $error("transport without plain ipv4");

  a_l3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({layer_flags_o[fmhp_pkg::FlArp],
      layer_flags_o[fmhp_pkg::FlIpv4], layer_flags_o[fmhp_pkg::FlMpls]}) <= 1)
    else $error("more than one network layer");

endmodule

bind flow_match_header_parser_core fmhp_checker u_fmhp_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .net_addrs_o, .layer_flags_o
);

>>> test/flow_match_checker.sv
module flow_match_checker
  import fmhp_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] in_port_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] port_out_i,
  input  logic [47:0] mac_source_i,
  input  logic [47:0] mac_dest_i,
  input  logic [15:0] ether_kind_i,
  input  logic [18:0] vlan_info_i,
  input  logic [22:0] mpls_info_i,
  input  logic [5:0]  dscp_i,
  input  logic [7:0]  net_proto_i,
  input  logic [63:0] net_addrs_i,
  input  logic [31:0] port_pair_i,
  input  logic [11:0] layer_flags_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    PhEth, PhVlan, PhMpls, PhArp, PhIpv4, PhL4, PhDone
  } phase_e;

  match_rec_t  expected_recs[$];
  phase_e      phase;
  int unsigned offset;
  logic [7:0]  hdr[HdrBytes];
  int unsigned fill;
  int unsigned l4_need;
  int unsigned l4_bit;
  logic [31:0] port_latch;
  logic [47:0] rec_src, rec_dst;
  logic [15:0] rec_etype;
  logic [18:0] rec_vlan;
  logic [22:0] rec_mpls;
  logic [5:0]  rec_dscp;
  logic [7:0]  rec_proto;
  logic [63:0] rec_addrs;
  logic [31:0] rec_ports;
  logic [11:0] rec_flags;
  logic [7:0]  mpls_ttl, ipv4_ttl;
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o = expected_recs.size();

  function automatic logic [63:0] hdr_be(int unsigned at, int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++) begin
      v = {v[55:0], (at + i < HdrBytes) ? hdr[at + i] : 8'h00};
    end
    return v;
  endfunction

  task automatic clear_frame();
    phase = PhEth;
    offset = 0;
    fill = 0;
    l4_need = 0;
    l4_bit = 0;
    rec_src = '0; rec_dst = '0; rec_etype = '0; rec_vlan = '0; rec_mpls = '0;
    rec_dscp = '0; rec_proto = '0; rec_addrs = '0; rec_ports = '0; rec_flags = '0;
    mpls_ttl = '0;
    ipv4_ttl = '0;
  endtask

  task automatic next_header(logic [15:0] etype, bit from_eth);
    rec_etype = etype;
    fill = 0;
    if (etype == EtVlan || etype == EtQinq) begin
      phase = PhVlan;
    end else begin
      if (from_eth) rec_vlan = {16'hffff, 3'd0};
      if (etype == EtMplsU || etype == EtMplsM) phase = PhMpls;
      else if (etype == EtArp) phase = PhArp;
      else if (etype == EtIpv4) phase = PhIpv4;
      else phase = PhDone;
    end
  endtask

  task automatic take_macs();
    rec_dst = 48'(hdr_be(0, 6));
    rec_src = 48'(hdr_be(6, 6));
  endtask

  task automatic close_header();
    logic [31:0] w;
    logic [15:0] op;
    case (phase)
      PhEth: begin
        if (fill == 14) begin
          rec_flags[FlEth] = 1'b1;
          if (hdr_be(12, 2) >= 64'h600) begin
            take_macs();
            next_header(16'(hdr_be(12, 2)), 1'b1);
          end
        end else if (fill == 17) begin
          if (hdr_be(14, 3) != 64'haaaa03) phase = PhDone;
        end else if (fill == 22) begin
          rec_flags[FlSnap] = 1'b1;
          if (hdr_be(17, 3) != 0) begin
            phase = PhDone;
          end else begin
            take_macs();
            next_header(16'(hdr_be(20, 2)), 1'b1);
          end
        end
      end
      PhVlan: begin
        if (fill == 4) begin
          if (!rec_flags[FlVlan]) begin
            w = 32'(hdr_be(0, 2));
            rec_flags[FlVlan] = 1'b1;
            rec_vlan = {4'h0, w[11:0], w[15:13]};
          end
          next_header(16'(hdr_be(2, 2)), 1'b0);
        end
      end
      PhMpls: begin
        if (fill == 4) begin
          w = 32'(hdr_be(0, 4));
          rec_flags[FlMpls] = 1'b1;
          rec_mpls = {w[31:12], w[11:9]};
          mpls_ttl = w[7:0];
          phase = PhDone;
        end
      end
      PhArp: begin
        if (fill == 28) begin
          rec_flags[FlArp] = 1'b1;
          if (hdr_be(0, 2) == 1 && hdr_be(2, 2) == 64'h0800 &&
              hdr[4] == 8'd6 && hdr[5] == 8'd4) begin
            op = 16'(hdr_be(6, 2));
            if (op <= 16'hff) begin
              rec_proto = op[7:0];
              if (op == 1 || op == 2) rec_addrs = {32'(hdr_be(14, 4)), 32'(hdr_be(24, 4))};
            end
          end
          phase = PhDone;
        end
      end
      PhIpv4: begin
        if (fill == 20) begin
          rec_flags[FlIpv4] = 1'b1;
          rec_addrs = {32'(hdr_be(12, 4)), 32'(hdr_be(16, 4))};
          rec_dscp = hdr[1][7:2];
          rec_proto = hdr[9];
          ipv4_ttl = hdr[8];
          phase = PhDone;
          fill = 0;
          if ((hdr_be(6, 2) & 64'h3fff) != 0) begin
            rec_flags[FlFrag] = 1'b1;
          end else if (hdr[9] == ProtoTcp) begin
            l4_need = 20; l4_bit = FlTcp; phase = PhL4;
          end else if (hdr[9] == ProtoUdp) begin
            l4_need = 8; l4_bit = FlUdp; phase = PhL4;
          end else if (hdr[9] == ProtoIcmp) begin
            l4_need = 4; l4_bit = FlIcmp; phase = PhL4;
          end else if (hdr[9] == ProtoSctp) begin
            l4_need = 12; l4_bit = FlSctp; phase = PhL4;
          end
        end
      end
      PhL4: begin
        if (fill == l4_need) begin
          rec_flags[l4_bit] = 1'b1;
          if (l4_bit == FlIcmp) rec_ports = {8'h00, hdr[0], 8'h00, hdr[1]};
          else rec_ports = 32'(hdr_be(0, 4));
          phase = PhDone;
        end
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(logic [7:0] d, logic last, logic [31:0] port);
    match_rec_t r;
    if (offset == 0) port_latch = port;
    if (offset < MaxFrameBytes) begin
      offset++;
      if (phase != PhDone) begin
        if (fill < HdrBytes) hdr[fill] = d;
        fill++;
        close_header();
      end
    end
    if (last) begin
      r.port_out = port_latch;
      r.mac_source = rec_src;
      r.mac_dest = rec_dst;
      r.ether_kind = rec_etype;
      r.vlan_info = rec_vlan;
      r.mpls_info = rec_mpls;
      r.dscp = rec_dscp;
      r.net_proto = rec_proto;
      r.net_addrs = rec_addrs;
      r.port_pair = rec_ports;
      r.layer_flags = {2'b00, rec_flags[9:0]};
      if (!(rec_flags[FlMpls] && mpls_ttl <= 1) && !(rec_flags[FlIpv4] && ipv4_ttl <= 1))
        r.layer_flags[FlTtl] = 1'b1;
      r.layer_flags[FlFrag] = rec_flags[FlFrag];
      expected_recs.push_back(r);
      clear_frame();
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  initial clear_frame();

  always @(posedge clk_i) begin
    match_rec_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_recs.size() == 0) begin
          report("unexpected record, port", 64'(port_out_i), '0);
        end else begin
          e = expected_recs.pop_front();
          check_field("port_out", 64'(port_out_i), 64'(e.port_out));
          check_field("mac_source", 64'(mac_source_i), 64'(e.mac_source));
          check_field("mac_dest", 64'(mac_dest_i), 64'(e.mac_dest));
          check_field("ether_kind", 64'(ether_kind_i), 64'(e.ether_kind));
          check_field("vlan_info", 64'(vlan_info_i), 64'(e.vlan_info));
          check_field("mpls_info", 64'(mpls_info_i), 64'(e.mpls_info));
          check_field("dscp", 64'(dscp_i), 64'(e.dscp));
          check_field("net_proto", 64'(net_proto_i), 64'(e.net_proto));
          check_field("net_addrs", net_addrs_i, e.net_addrs);
          check_field("port_pair", 64'(port_pair_i), 64'(e.port_pair));
          check_field("layer_flags", 64'(layer_flags_i), 64'(e.layer_flags));
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(data_byte_i, last_byte_i, in_port_i);
    end
  end
endmodule

>>> test/tb_flow_match_header_parser_core.sv
module tb_flow_match_header_parser_core;
  import fmhp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    KindIpv4, KindArp, KindMpls, KindOther, KindSnap, KindLlc, KindNoise
  } frame_kind_e;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned MinBytes = 1050;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [31:0] in_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] port_out;
  logic [47:0] mac_source, mac_dest;
  logic [15:0] ether_kind;
  logic [18:0] vlan_info;
  logic [22:0] mpls_info;
  logic [5:0]  dscp;
  logic [7:0]  net_proto;
  logic [63:0] net_addrs;
  logic [31:0] port_pair;
  logic [11:0] layer_flags;
  int          fail_count, pending;
  bit          quiet = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned bytes_sent = 0;
  logic [7:0]  frame_q[$];

  flow_match_header_parser_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .data_byte_i(data_byte), .last_byte_i(last_byte), .in_port_i(in_port),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .port_out_o(port_out), .mac_source_o(mac_source), .mac_dest_o(mac_dest),
    .ether_kind_o(ether_kind), .vlan_info_o(vlan_info), .mpls_info_o(mpls_info),
    .dscp_o(dscp), .net_proto_o(net_proto), .net_addrs_o(net_addrs),
    .port_pair_o(port_pair), .layer_flags_o(layer_flags)
  );

  flow_match_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .data_byte_i(data_byte), .last_byte_i(last_byte), .in_port_i(in_port),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .port_out_i(port_out), .mac_source_i(mac_source), .mac_dest_i(mac_dest),
    .ether_kind_i(ether_kind), .vlan_info_i(vlan_info), .mpls_info_i(mpls_info),
    .dscp_i(dscp), .net_proto_i(net_proto), .net_addrs_i(net_addrs),
    .port_pair_i(port_pair), .layer_flags_i(layer_flags),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= !quiet ? 1'b0 : 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_flow_match_header_parser_core: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] d, logic last);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    last_byte <= last;
    in_port <= $urandom;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic put16(logic [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic put_rand(int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  function automatic logic [7:0] pick_ttl();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
  endfunction

  task automatic build_frame(frame_kind_e kind);
    frame_kind_e inner;
    logic [15:0] etype;
    logic [7:0]  proto;
    int unsigned ntags, cut;
    frame_q.delete();
    if (kind == KindNoise) begin
      put_rand($urandom_range(1, 30));
      return;
    end
    case ($urandom_range(0, 5))
      0: repeat (12) frame_q.push_back(8'h00);
      1: repeat (12) frame_q.push_back(8'hff);
      default: put_rand(12);
    endcase
    inner = kind;
    if (kind == KindSnap || kind == KindLlc) begin
      put16(16'($urandom_range(0, 16'h5ff)));
      if (kind == KindLlc && $urandom_range(0, 1)) put_rand(3);
      else begin
        frame_q.push_back(8'haa); frame_q.push_back(8'haa); frame_q.push_back(8'h03);
      end
      if (kind == KindLlc) put_rand(3);
      else repeat (3) frame_q.push_back(8'h00);
      inner = frame_kind_e'($urandom_range(KindIpv4, KindOther));
    end
    ntags = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (ntags) begin
      put16($urandom_range(0, 1) ? EtVlan : EtQinq);
      put_rand(2);
    end
    case (inner)
      KindIpv4: begin
        put16(EtIpv4);
        frame_q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h45);
        put_rand(5);
        if ($urandom_range(0, 3) == 0) put_rand(2);
        else put16(16'h4000 & 16'($urandom));
        frame_q.push_back(pick_ttl());
        case ($urandom_range(0, 4))
          0: proto = ProtoTcp;
          1: proto = ProtoUdp;
          2: proto = ProtoIcmp;
          3: proto = ProtoSctp;
          default: proto = 8'($urandom);
        endcase
        frame_q.push_back(proto);
        put_rand(10 + 20 + $urandom_range(0, 6));
      end
      KindArp: begin
        put16(EtArp);
        if ($urandom_range(0, 4) == 0) begin
          put_rand(6);
        end else begin
          put16(16'd1); put16(EtIpv4);
          frame_q.push_back(8'd6); frame_q.push_back(8'd4);
        end
        case ($urandom_range(0, 3))
          0: put_rand(2);
          1: put16(16'($urandom_range(0, 255)));
          default: put16(16'($urandom_range(1, 2)));
        endcase
        put_rand(20 + $urandom_range(0, 4));
      end
      KindMpls: begin
        put16($urandom_range(0, 1) ? EtMplsU : EtMplsM);
        put_rand(3);
        frame_q.push_back(pick_ttl());
        put_rand($urandom_range(0, 6));
      end
      default: begin
        etype = 16'($urandom);
        put16(etype);
        put_rand($urandom_range(0, 8));
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  initial begin
    int unsigned frames;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-byte frames, all-ones header, zero bytes
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'hff};
    send_frame();
    frame_q.delete();
    repeat (14) frame_q.push_back(8'hff);
    send_frame();
    frame_q.delete();
    repeat (6) frame_q.push_back(8'h00);
    send_frame();

    frames = 0;
    while (bytes_sent < MinBytes) begin
      if (frames == 10) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      build_frame(frame_kind_e'($urandom_range(KindIpv4, KindNoise)));
      if (bytes_sent >= MinBytes * 9 / 10) quiet = 1'b1;
      send_frame();
      frames++;
    end
    in_valid <= 1'b0;
    quiet = 1'b1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_flow_match_header_parser_core: PASS");
    end else begin
      $display("tb_flow_match_header_parser_core: FAIL");
    end
    $finish;
  end
endmodule
